[design/nfca_pkg.sv]
`default_nettype none

package nfca_pkg;

    localparam int FIELD_W = 3;
    localparam int MASK_W  = 64;

    typedef logic [FIELD_W-1:0] coord_t;
    typedef logic [2:0]         status_t;

    localparam logic REQ_PLACE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam status_t ST_NEAREST     = 3'd0;
    localparam status_t ST_MOVED       = 3'd1;
    localparam status_t ST_NOT_ALLOWED = 3'd2;
    localparam status_t ST_NONE_FREE   = 3'd3;
    localparam status_t ST_CLEARED     = 3'd4;

    typedef struct packed {
        logic first;
        logic last;
    } walk_t;

endpackage

`default_nettype wire

[design/nfca_cfg_if.sv]
`default_nettype none

interface nfca_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [nfca_pkg::MASK_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/nfca_req_if.sv]
`default_nettype none

interface nfca_req_if;
    logic             valid;
    logic             ready;
    logic             req_type;
    nfca_pkg::coord_t nearest_col;
    nfca_pkg::coord_t nearest_row;

    modport source (output valid, output req_type, output nearest_col, output nearest_row,
                    input ready);
    modport sink   (input valid, input req_type, input nearest_col, input nearest_row,
                    output ready);
endinterface

`default_nettype wire

[design/nfca_res_if.sv]
`default_nettype none

interface nfca_res_if;
    logic              valid;
    logic              ready;
    nfca_pkg::coord_t  placed_col;
    nfca_pkg::coord_t  placed_row;
    nfca_pkg::status_t status;

    modport source (output valid, output placed_col, output placed_row, output status,
                    input ready);
    modport sink   (input valid, input placed_col, input placed_row, input status,
                    output ready);
endinterface

`default_nettype wire

[design/nfca_walker.sv]
`default_nettype none

// Walks the search order: columns from the start column round the row,
// then on to the next row, wrapping to row 0.
module nfca_walker #(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              load,
    input  wire              step,
    input  nfca_pkg::coord_t start_col,
    input  nfca_pkg::coord_t start_row,
    output nfca_pkg::coord_t col,
    output nfca_pkg::coord_t row,
    output nfca_pkg::walk_t  walk
);

    localparam nfca_pkg::coord_t COL_LAST = nfca_pkg::FIELD_W'(GRID_COLS - 1);
    localparam nfca_pkg::coord_t ROW_LAST = nfca_pkg::FIELD_W'(GRID_ROWS - 1);

    nfca_pkg::coord_t col_reg, col_next;
    nfca_pkg::coord_t row_reg, row_next;
    nfca_pkg::coord_t col_cnt_reg, col_cnt_next;
    nfca_pkg::coord_t row_cnt_reg, row_cnt_next;
    logic             first_reg, first_next;

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        first_next   = first_reg;
        if (load)
        begin
            col_next     = start_col;
            row_next     = start_row;
            col_cnt_next = '0;
            row_cnt_next = '0;
            first_next   = 1'b1;
        end
        else if (step)
        begin
            first_next = 1'b0;
            col_next   = (col_reg == COL_LAST) ? '0 : col_reg + 1'b1;
            if (col_cnt_reg == COL_LAST)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_cnt_reg + 1'b1;
                row_next     = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            first_reg   <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            first_reg   <= first_next;
        end
    end

    assign col        = col_reg;
    assign row        = row_reg;
    assign walk.first = first_reg;
    assign walk.last  = (col_cnt_reg == COL_LAST) && (row_cnt_reg == ROW_LAST);

endmodule

`default_nettype wire

[design/nearest_free_core_allocator.sv]
// Nearest free cell allocator over a GRID_COLS x GRID_ROWS grid.
// Channels: cfg writes allowed_mask (bit row*GRID_COLS+col), always ready;
// write only while idle. req carries one request beat: place near
// (nearest_col, nearest_row) or clear all taken marks. res returns one beat
// per request: placed cell and status.
// Search: a clear goes through the S_CLEAR state to the output register. A place
// request tests one cell per cycle through a single bit lookup, walking
// from the preferred cell until a free cell is found or every cell is tested.
// Throughput: one request at a time; req is ready again once the result is
// loaded into the output register, even if res has not taken it.
// Stall: while a result waits in the output register the next request runs
// but holds its final cycle until the register frees.
// Reset: mask and taken map are zero, no result pending, req ready.
`default_nettype none

module nearest_free_core_allocator #(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 8
) (
    input  wire             clk,
    input  wire             rst_n,
    nfca_cfg_if.sink        cfg,
    nfca_req_if.sink        req,
    nfca_res_if.source      res
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_CLEAR = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CELLS-1:0] allowed_reg;
    logic [CELLS-1:0] taken_reg, taken_next;

    logic              out_valid_reg, out_valid_next;
    nfca_pkg::coord_t  out_col_reg, out_col_next;
    nfca_pkg::coord_t  out_row_reg, out_row_next;
    nfca_pkg::status_t out_status_reg, out_status_next;

    nfca_pkg::coord_t walk_col, walk_row;
    nfca_pkg::walk_t  walk;
    logic             walk_load, walk_step;

    logic             slot_free;
    logic             in_grid;
    logic [IDX_W-1:0] idx;
    logic             cell_ok, cell_free;

    nfca_walker #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (walk_load),
        .step      (walk_step),
        .start_col (req.nearest_col),
        .start_row (req.nearest_row),
        .col       (walk_col),
        .row       (walk_row),
        .walk      (walk)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign slot_free = !out_valid_reg || res.ready;
    assign in_grid   = (int'(walk_col) < GRID_COLS) && (int'(walk_row) < GRID_ROWS);
    assign idx       = IDX_W'(int'(walk_row) * GRID_COLS + int'(walk_col));
    assign cell_ok   = allowed_reg[idx];
    assign cell_free = cell_ok && !taken_reg[idx];

    always_comb
    begin
        state_next      = state_reg;
        taken_next      = taken_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_status_next = out_status_reg;
        walk_load       = 1'b0;
        walk_step       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == nfca_pkg::REQ_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                        walk_load  = 1'b1;
                    end
                end
            end
            S_CLEAR:
            begin
                if (slot_free)
                begin
                    taken_next      = '0;
                    out_valid_next  = 1'b1;
                    out_col_next    = '0;
                    out_row_next    = '0;
                    out_status_next = nfca_pkg::ST_CLEARED;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (walk.first && (!in_grid || !cell_ok))
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_col_next    = '0;
                        out_row_next    = '0;
                        out_status_next = nfca_pkg::ST_NOT_ALLOWED;
                        state_next      = S_IDLE;
                    end
                end
                else if (cell_free)
                begin
                    if (slot_free)
                    begin
                        taken_next[idx] = 1'b1;
                        out_valid_next  = 1'b1;
                        out_col_next    = walk_col;
                        out_row_next    = walk_row;
                        out_status_next = walk.first ? nfca_pkg::ST_NEAREST
                                                     : nfca_pkg::ST_MOVED;
                        state_next      = S_IDLE;
                    end
                end
                else if (walk.last)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_col_next    = '0;
                        out_row_next    = '0;
                        out_status_next = nfca_pkg::ST_NONE_FREE;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    walk_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            allowed_reg   <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                allowed_reg <= cfg.data[CELLS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_status_reg <= out_status_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.placed_col = out_col_reg;
    assign res.placed_row = out_row_reg;
    assign res.status     = out_status_reg;

endmodule

`default_nettype wire

[design/nfca_checker.sv]
`default_nettype none

module nfca_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    req_valid,
    input wire                    req_ready,
    input wire                    res_valid,
    input wire                    res_ready,
    input wire nfca_pkg::coord_t  placed_col,
    input wire nfca_pkg::coord_t  placed_row,
    input wire nfca_pkg::status_t status
);

    // only one request in flight: ready drops after a request beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req ready after accepted beat");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == nfca_pkg::ST_NEAREST || status == nfca_pkg::ST_MOVED ||
                       status == nfca_pkg::ST_NOT_ALLOWED ||
                       status == nfca_pkg::ST_NONE_FREE || status == nfca_pkg::ST_CLEARED))
        else $error("bad status code");

    a_zero_on_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == nfca_pkg::ST_NOT_ALLOWED || status == nfca_pkg::ST_NONE_FREE ||
                      status == nfca_pkg::ST_CLEARED)
        |-> (placed_col == '0 && placed_row == '0))
        else $error("non-zero cell on error or clear");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(placed_col) && $stable(placed_row)
                                    && $stable(status))
        else $error("result beat changed while stalled");

endmodule

bind nearest_free_core_allocator nfca_checker u_nfca_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .placed_col (res.placed_col),
    .placed_row (res.placed_row),
    .status     (res.status)
);

`default_nettype wire

[tb/tb_nearest_free_core_allocator.sv]
`timescale 1ns / 100ps

module tb_nearest_free_core_allocator;

    localparam int GRID_COLS   = 8;
    localparam int GRID_ROWS   = 8;
    localparam int ANSWER_WAIT = GRID_COLS * GRID_ROWS + 6;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 70;

    typedef struct packed {
        nfca_pkg::coord_t  col;
        nfca_pkg::coord_t  row;
        nfca_pkg::status_t st;
    } cell_ans_t;

    typedef struct packed {
        logic      chk;
        cell_ans_t ans;
    } typed_ans_t;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [nfca_pkg::MASK_W-1:0] mask;
        logic                        rt;
        nfca_pkg::coord_t            col;
        nfca_pkg::coord_t            row;
        logic                        chk;
        cell_ans_t                   ans;
    } dir_row_t;

    localparam logic [nfca_pkg::MASK_W-1:0] MASK_ALL     = {nfca_pkg::MASK_W{1'b1}};
    localparam logic [nfca_pkg::MASK_W-1:0] MASK_CORNERS = 64'h8000_0000_0000_0001;
    localparam logic [nfca_pkg::MASK_W-1:0] MASK_SPARSE  = 64'h00FF_0000_0000_0081;

    localparam logic              P_PL = nfca_pkg::REQ_PLACE;
    localparam logic              P_CL = nfca_pkg::REQ_CLEAR;
    localparam nfca_pkg::status_t S_NE = nfca_pkg::ST_NEAREST;
    localparam nfca_pkg::status_t S_MV = nfca_pkg::ST_MOVED;
    localparam nfca_pkg::status_t S_NA = nfca_pkg::ST_NOT_ALLOWED;
    localparam nfca_pkg::status_t S_NF = nfca_pkg::ST_NONE_FREE;
    localparam nfca_pkg::status_t S_CL = nfca_pkg::ST_CLEARED;

    localparam int DIR_N = 24;
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{ROW_REQ, 64'h0, P_PL, 3'd0, 3'd0, 1'b1, '{3'd0, 3'd0, S_NA}},
        '{ROW_REQ, 64'h0, P_PL, 3'd7, 3'd7, 1'b1, '{3'd0, 3'd0, S_NA}},
        '{ROW_REQ, 64'h0, P_CL, 3'd0, 3'd0, 1'b1, '{3'd0, 3'd0, S_CL}},
        '{ROW_CFG, MASK_ALL, P_PL, 3'd0, 3'd0, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd0, 3'd0, 1'b1, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd7, 3'd7, 1'b1, '{3'd7, 3'd7, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd0, 3'd0, 1'b1, '{3'd1, 3'd0, S_MV}},
        '{ROW_REQ, 64'h0, P_PL, 3'd7, 3'd7, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd5, 3'd3, 1'b1, '{3'd5, 3'd3, S_NE}},
        '{ROW_REQ, 64'h0, P_CL, 3'd7, 3'd7, 1'b1, '{3'd0, 3'd0, S_CL}},
        '{ROW_CFG, MASK_CORNERS, P_PL, 3'd0, 3'd0, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd3, 3'd3, 1'b1, '{3'd0, 3'd0, S_NA}},
        '{ROW_REQ, 64'h0, P_PL, 3'd7, 3'd7, 1'b1, '{3'd7, 3'd7, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd7, 3'd7, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd0, 3'd0, 1'b1, '{3'd0, 3'd0, S_NF}},
        '{ROW_REQ, 64'h0, P_PL, 3'd7, 3'd7, 1'b1, '{3'd0, 3'd0, S_NF}},
        '{ROW_REQ, 64'h0, P_CL, 3'd0, 3'd0, 1'b1, '{3'd0, 3'd0, S_CL}},
        '{ROW_CFG, MASK_SPARSE, P_PL, 3'd0, 3'd0, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd0, 3'd0, 1'b1, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd0, 3'd0, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd0, 3'd0, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd3, 3'd6, 1'b1, '{3'd3, 3'd6, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd3, 3'd6, 1'b0, '{3'd0, 3'd0, S_NE}},
        '{ROW_REQ, 64'h0, P_PL, 3'd7, 3'd0, 1'b0, '{3'd0, 3'd0, S_NE}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic calm  = 1'b0;

    int unsigned stall_left   = 0;
    int unsigned quiet_left   = 0;
    int unsigned mismatch_cnt = 0;

    logic [nfca_pkg::MASK_W-1:0] allowed_m = '0;
    logic [nfca_pkg::MASK_W-1:0] taken_m   = '0;

    cell_ans_t  placements_due [$];
    typed_ans_t typed_due [$];

    nfca_cfg_if cfg_ch ();
    nfca_req_if req_ch ();
    nfca_res_if res_ch ();

    nearest_free_core_allocator #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .res   (res_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic cell_ans_t allocate_cell(input logic rt, input nfca_pkg::coord_t col,
                                                input nfca_pkg::coord_t row);
        cell_ans_t o;
        int        i;
        int        k;
        int        ci;
        int        ri;
        int        idx;
        o = '{3'd0, 3'd0, nfca_pkg::ST_NOT_ALLOWED};
        if (rt == nfca_pkg::REQ_CLEAR)
        begin
            taken_m = '0;
            o.st    = nfca_pkg::ST_CLEARED;
            return o;
        end
        if (int'(col) >= GRID_COLS || int'(row) >= GRID_ROWS)
            return o;
        idx = int'(row) * GRID_COLS + int'(col);
        if (!allowed_m[idx])
            return o;
        if (!taken_m[idx])
        begin
            taken_m[idx] = 1'b1;
            o = '{col, row, nfca_pkg::ST_NEAREST};
            return o;
        end
        // rows upward with wrap; within a row, columns from the preferred one with wrap
        for (i = 0; i < GRID_ROWS; i++)
        begin
            ri = (int'(row) + i) % GRID_ROWS;
            for (k = 0; k < GRID_COLS; k++)
            begin
                ci  = (int'(col) + k) % GRID_COLS;
                idx = ri * GRID_COLS + ci;
                if (allowed_m[idx] && !taken_m[idx])
                begin
                    taken_m[idx] = 1'b1;
                    o = '{nfca_pkg::coord_t'(ci), nfca_pkg::coord_t'(ri), nfca_pkg::ST_MOVED};
                    return o;
                end
            end
        end
        o.st = nfca_pkg::ST_NONE_FREE;
        return o;
    endfunction

    task automatic drive_item(input logic rt, input nfca_pkg::coord_t col,
                              input nfca_pkg::coord_t row, input typed_ans_t tag);
        typed_due = {typed_due, tag};
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.nearest_col <= col;
        req_ch.nearest_row <= row;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic write_mask(input logic [nfca_pkg::MASK_W-1:0] m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (placements_due.size() != 0 || typed_due.size() != 0)
            @(posedge clk);
        repeat (ANSWER_WAIT) @(posedge clk);
    endtask

    // result sink with stall bursts and quiet stretches
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (calm)
            res_ch.ready <= 1'b1;
        else if (quiet_left != 0)
        begin
            quiet_left   <= quiet_left - 1;
            res_ch.ready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 15))
                0, 1:
                begin
                    stall_left   <= $urandom_range(0, 12);
                    res_ch.ready <= 1'b0;
                end
                2:
                begin
                    quiet_left   <= $urandom_range(20, 120);
                    res_ch.ready <= 1'b1;
                end
                default:
                    res_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cell_ans_t  got;
        cell_ans_t  want;
        cell_ans_t  guess;
        typed_ans_t tag;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                allowed_m = cfg_ch.data;
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{res_ch.placed_col, res_ch.placed_row, res_ch.status};
                if (placements_due.size() == 0)
                begin
                    $display("%0t: unexpected beat, col %0d row %0d status %0d",
                             $time, got.col, got.row, got.st);
                    mismatch_cnt++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (got.col !== want.col)
                    begin
                        $display("%0t: placed_col expected %0d actual %0d",
                                 $time, want.col, got.col);
                        mismatch_cnt++;
                    end
                    if (got.row !== want.row)
                    begin
                        $display("%0t: placed_row expected %0d actual %0d",
                                 $time, want.row, got.row);
                        mismatch_cnt++;
                    end
                    if (got.st !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, got.st);
                        mismatch_cnt++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                guess = allocate_cell(req_ch.req_type, req_ch.nearest_col, req_ch.nearest_row);
                tag   = typed_due.pop_front();
                placements_due = {placements_due, (tag.chk ? tag.ans : guess)};
            end
        end
    end

    initial
    begin
        int unsigned                 p;
        int unsigned                 k;
        int unsigned                 clr_pct;
        int unsigned                 hold_at;
        logic                        gap_on;
        logic                        rt;
        logic [nfca_pkg::MASK_W-1:0] m;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = nfca_pkg::REQ_PLACE;
        req_ch.nearest_col = '0;
        req_ch.nearest_row = '0;
        res_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_N; k++)
        begin
            if (DIR_TAB[k].kind == ROW_CFG)
            begin
                settle();
                write_mask(DIR_TAB[k].mask);
            end
            else
                drive_item(DIR_TAB[k].rt, DIR_TAB[k].col, DIR_TAB[k].row,
                           '{DIR_TAB[k].chk, DIR_TAB[k].ans});
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            calm = (p == PHASES - 1);
            case (p)
                0, 8: m = MASK_ALL;
                2:    m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                3:    m = {$urandom, $urandom} | {$urandom, $urandom};
                4:    m = '0;
                5:    m = 64'hFF << (8 * $urandom_range(0, 7));
                6:    m = 64'h1 << $urandom_range(0, 63);
                default: m = {$urandom, $urandom};
            endcase
            write_mask(m);
            clr_pct = (p % 3 == 0) ? 2 : 10;
            gap_on  = (p != 2) && !calm;
            hold_at = $urandom_range(10, 60);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == hold_at && !calm)
                    settle();
                else if (gap_on && $urandom_range(0, 3) == 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 13)) @(posedge clk);
                end
                rt = ($urandom_range(0, 99) < clr_pct) ? nfca_pkg::REQ_CLEAR
                                                        : nfca_pkg::REQ_PLACE;
                drive_item(rt, nfca_pkg::coord_t'($urandom_range(0, 7)),
                           nfca_pkg::coord_t'($urandom_range(0, 7)), '0);
            end
        end

        settle();
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
